// ===== hw/rtl/bpmb_pkg.sv =====
package bpmb_pkg;

  // operation codes carried in the input tuser
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_EVAL   = 1'b1;

  // result kinds carried in the output tuser
  localparam logic KIND_BOARD = 1'b0;
  localparam logic KIND_PACK  = 1'b1;

  // balance actions
  localparam logic [1:0] ACT_DISCHARGE = 2'd0;
  localparam logic [1:0] ACT_HOLD      = 2'd1;
  localparam logic [1:0] ACT_PEC_ERR   = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_LOW_THR  = 3'd0;
  localparam logic [2:0] REG_HIGH_THR = 3'd1;
  localparam logic [2:0] REG_MARGIN   = 3'd2;
  localparam logic [2:0] REG_FLOOR    = 3'd3;
  localparam logic [2:0] REG_LOW_LIM  = 3'd4;
  localparam logic [2:0] REG_HIGH_LIM = 3'd5;

  localparam logic [15:0] RST_LOW_THR  = 16'd30500;
  localparam logic [15:0] RST_HIGH_THR = 16'd41800;
  localparam logic [15:0] RST_MARGIN   = 16'd150;
  localparam logic [15:0] RST_FLOOR    = 16'd32000;
  localparam logic [7:0]  RST_LOW_LIM  = 8'd5;
  localparam logic [7:0]  RST_HIGH_LIM = 8'd10;

  typedef struct packed {
    logic [15:0] low_thr;
    logic [15:0] high_thr;
    logic [15:0] margin;
    logic [15:0] floor;
    logic [7:0]  low_lim;
    logic [7:0]  high_lim;
  } cfg_t;

  // classified input item, as queued between front and back
  typedef struct packed {
    logic        eval;
    logic        store_en;
    logic        cand;
    logic        last;
    logic        pec;
    logic [15:0] code;
    logic [6:0]  pos;
    logic [3:0]  idx;
  } item_t;

  typedef struct packed {
    logic        kind;
    logic [1:0]  action;
    logic [11:0] mask;
    logic [15:0] pmin;
    logic [15:0] pmax;
    logic [15:0] pavg;
    logic [22:0] total;
    logic        low_fault;
    logic        high_fault;
    logic        report;
  } res_t;

endpackage

// ===== hw/rtl/battery_pack_monitor_balancer.sv =====
// Channel   Dir  Handshake                 Payload
// s_axis    in   s_axis_tvalid/tready      tdata: cell sample, tuser: operation, tlast
// m_axis    out  m_axis_tvalid/tready      tdata: result fields, tuser: result kind
// cfg       in   cfg_valid_i/cfg_ready_o   cfg_addr_i register index, cfg_data_i value
//
// A cell sample is taken by the back end in its idle state; a two-beat queue sits in front.
// An evaluate beat walks the cell store, one RAM read a cycle through the single read port,
// then runs the three-step reciprocal divide for the average.
// Reset leaves the store contents as they are; per-entry valid bits make unwritten
// cells read as zero, so there is no clearing pass.
// A stalled output holds the back end; the input queue keeps taking beats until full.
module battery_pack_monitor_balancer #(
  parameter int NUM_CELLS       = 96,
  parameter int CELLS_PER_BOARD = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // cell_code[15:0], pack_position[22:16], cell_in_board[26:23], pec_ok[27]
  input  logic [31:0] s_axis_tdata,
  // operation[0]
  input  logic        s_axis_tuser,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // balance_action[1:0], discharge_mask[13:2], pack_minimum[29:14],
  // pack_maximum[45:30], pack_average[61:46], pack_total[84:62],
  // low_fault[85], high_fault[86], fault_report[87]
  output logic [87:0] m_axis_tdata,
  // result_kind[0]
  output logic        m_axis_tuser,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_addr_i,
  input  logic [15:0] cfg_data_i
);

  bpmb_pkg::cfg_t  cfg_q;
  bpmb_pkg::item_t item;
  logic            item_valid;
  logic            item_pop;
  bpmb_pkg::res_t  res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_thr  <= bpmb_pkg::RST_LOW_THR;
      cfg_q.high_thr <= bpmb_pkg::RST_HIGH_THR;
      cfg_q.margin   <= bpmb_pkg::RST_MARGIN;
      cfg_q.floor    <= bpmb_pkg::RST_FLOOR;
      cfg_q.low_lim  <= bpmb_pkg::RST_LOW_LIM;
      cfg_q.high_lim <= bpmb_pkg::RST_HIGH_LIM;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        bpmb_pkg::REG_LOW_THR:  cfg_q.low_thr  <= cfg_data_i;
        bpmb_pkg::REG_HIGH_THR: cfg_q.high_thr <= cfg_data_i;
        bpmb_pkg::REG_MARGIN:   cfg_q.margin   <= cfg_data_i;
        bpmb_pkg::REG_FLOOR:    cfg_q.floor    <= cfg_data_i;
        bpmb_pkg::REG_LOW_LIM:  cfg_q.low_lim  <= cfg_data_i[7:0];
        bpmb_pkg::REG_HIGH_LIM: cfg_q.high_lim <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  bpmb_front #(
    .NUM_CELLS       (NUM_CELLS),
    .CELLS_PER_BOARD (CELLS_PER_BOARD)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .s_axis_tlast_i  (s_axis_tlast),
    .item_o          (item),
    .item_valid_o    (item_valid),
    .item_pop_i      (item_pop)
  );

  bpmb_back #(
    .NUM_CELLS       (NUM_CELLS),
    .CELLS_PER_BOARD (CELLS_PER_BOARD)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_pop_o   (item_pop),
    .res_o        (res),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready)
  );

  assign m_axis_tuser = res.kind;
  assign m_axis_tdata = {res.report, res.high_fault, res.low_fault, res.total,
                         res.pavg, res.pmax, res.pmin, res.mask, res.action};

endmodule

// ===== hw/rtl/bpmb_ram.sv =====
module bpmb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 96
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== hw/rtl/bpmb_front.sv =====
module bpmb_front #(
  parameter int NUM_CELLS       = 96,
  parameter int CELLS_PER_BOARD = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [31:0]          s_axis_tdata_i,
  input  logic                 s_axis_tuser_i,
  input  logic                 s_axis_tlast_i,
  output bpmb_pkg::item_t      item_o,
  output logic                 item_valid_o,
  input  logic                 item_pop_i
);

  bpmb_pkg::item_t it;
  bpmb_pkg::item_t q_mem [2];
  logic            wptr_q, wptr_d;
  logic            rptr_q, rptr_d;
  logic [1:0]      cnt_q, cnt_d;
  logic            push;

  // classify the incoming beat
  always_comb begin
    it.eval     = (s_axis_tuser_i == bpmb_pkg::OP_EVAL);
    it.code     = s_axis_tdata_i[15:0];
    it.pos      = s_axis_tdata_i[22:16];
    it.idx      = s_axis_tdata_i[26:23];
    it.pec      = s_axis_tdata_i[27];
    it.last     = s_axis_tlast_i;
    it.store_en = 9'(it.pos) < 9'(NUM_CELLS);
    it.cand     = 5'(it.idx) < 5'(CELLS_PER_BOARD);
  end

  assign s_axis_tready_o = (cnt_q != 2'd2);
  assign push            = s_axis_tvalid_i && s_axis_tready_o;
  assign item_valid_o    = (cnt_q != 2'd0);
  assign item_o          = q_mem[rptr_q];

  always_comb begin
    wptr_d = push ? ~wptr_q : wptr_q;
    rptr_d = item_pop_i ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + 2'(push) - 2'(item_pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wptr_q] <= it;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ===== hw/rtl/bpmb_back.sv =====
module bpmb_back #(
  parameter int NUM_CELLS       = 96,
  parameter int CELLS_PER_BOARD = 12
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bpmb_pkg::cfg_t  cfg_i,
  input  bpmb_pkg::item_t item_i,
  input  logic            item_valid_i,
  output logic            item_pop_o,
  output bpmb_pkg::res_t  res_o,
  output logic            res_valid_o,
  input  logic            res_ready_i
);

  localparam int ADDR_W  = $clog2(NUM_CELLS);
  localparam int CNT_W   = $clog2(NUM_CELLS + 1);
  localparam int TOTAL_W = 16 + $clog2(NUM_CELLS);
  localparam int PROD_W  = TOTAL_W + 32;
  localparam logic [31:0] RECIP = 32'(64'h1_0000_0000 / 64'(NUM_CELLS));

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_WALK = 3'd1;
  localparam logic [2:0] ST_DIV1 = 3'd2;
  localparam logic [2:0] ST_DIV2 = 3'd3;
  localparam logic [2:0] ST_DIV3 = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0]         state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [NUM_CELLS-1:0] vld_q;
  logic               rd_vld_q;
  logic [15:0]        rd_data;
  logic [15:0]        mn_q, mn_d, mx_q, mx_d;
  logic [TOTAL_W-1:0] sum_q, sum_d;
  logic [PROD_W-1:0]  prod_q;
  logic [15:0]        quo_q;
  logic [TOTAL_W-1:0] qn_q;
  logic [15:0]        bmax_q, bmax_d;
  logic [3:0]         bidx_q, bidx_d;
  logic [15:0]        pmin_q, pmin_d;
  logic               bal_en_q, bal_en_d;
  logic [7:0]         lcnt_q, lcnt_d, hcnt_q, hcnt_d;
  logic               lflag_q, lflag_d, hflag_q, hflag_d;
  bpmb_pkg::res_t     out_q, out_d;
  logic               out_valid_q, out_valid_d;

  logic               out_free;
  logic               pop_sample;
  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  waddr, raddr;
  logic [15:0]        eff_max;
  logic [3:0]         eff_idx;
  logic [16:0]        min_plus;
  logic [15:0]        walk_v;
  logic [TOTAL_W-1:0] rem;
  logic               rep;

  assign out_free    = !out_valid_q || res_ready_i;
  assign item_pop_o  = item_valid_i && (state_q == ST_IDLE) && out_free;
  assign pop_sample  = item_pop_o && !item_i.eval;
  assign ram_we      = pop_sample && item_i.store_en;
  assign waddr       = ADDR_W'(item_i.pos);
  assign ram_re      = (state_q == ST_WALK) && (cnt_q != CNT_W'(NUM_CELLS));
  assign raddr       = cnt_q[ADDR_W-1:0];
  assign res_o       = out_q;
  assign res_valid_o = out_valid_q;

  bpmb_ram #(
    .WIDTH (16),
    .DEPTH (NUM_CELLS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (item_i.code),
    .re_i    (ram_re),
    .raddr_i (raddr),
    .rdata_o (rd_data)
  );

  // running board maximum including the current sample; ties keep the first
  always_comb begin
    eff_max = bmax_q;
    eff_idx = bidx_q;
    if (item_i.cand && (item_i.code > bmax_q)) begin
      eff_max = item_i.code;
      eff_idx = item_i.idx;
    end
  end

  assign min_plus = {1'b0, pmin_q} + {1'b0, cfg_i.margin};
  assign walk_v   = rd_vld_q ? rd_data : 16'd0;
  assign rem      = sum_q - qn_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    mn_d        = mn_q;
    mx_d        = mx_q;
    sum_d       = sum_q;
    bmax_d      = bmax_q;
    bidx_d      = bidx_q;
    pmin_d      = pmin_q;
    bal_en_d    = bal_en_q;
    lcnt_d      = lcnt_q;
    hcnt_d      = hcnt_q;
    lflag_d     = lflag_q;
    hflag_d     = hflag_q;
    rep         = 1'b0;
    out_d       = out_q;
    out_valid_d = out_valid_q && !res_ready_i;

    case (state_q)
      ST_IDLE: begin
        if (item_pop_o) begin
          if (item_i.eval) begin
            state_d = ST_WALK;
            cnt_d   = '0;
            mn_d    = 16'hFFFF;
            mx_d    = 16'd0;
            sum_d   = '0;
          end else if (item_i.last) begin
            out_d            = '0;
            out_d.kind       = bpmb_pkg::KIND_BOARD;
            out_d.low_fault  = lflag_q;
            out_d.high_fault = hflag_q;
            if (!item_i.pec) begin
              out_d.action = bpmb_pkg::ACT_PEC_ERR;
            end else if (bal_en_q && ({1'b0, eff_max} > min_plus) &&
                         (eff_max > cfg_i.floor)) begin
              out_d.action = bpmb_pkg::ACT_DISCHARGE;
              out_d.mask   = 12'(16'd1 << eff_idx);
            end else begin
              out_d.action = bpmb_pkg::ACT_HOLD;
            end
            out_valid_d = 1'b1;
            bmax_d      = 16'd0;
            bidx_d      = 4'd0;
          end else begin
            bmax_d = eff_max;
            bidx_d = eff_idx;
          end
        end
      end
      ST_WALK: begin
        // read data comes back in the cycle after its address
        if (cnt_q != '0) begin
          sum_d = sum_q + TOTAL_W'(walk_v);
          if (walk_v < mn_q) mn_d = walk_v;
          if (walk_v > mx_q) mx_d = walk_v;
        end
        if (cnt_q == CNT_W'(NUM_CELLS)) begin
          state_d = ST_DIV1;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_DIV1: state_d = ST_DIV2;
      ST_DIV2: state_d = ST_DIV3;
      ST_DIV3: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          if (mn_q < cfg_i.low_thr) begin
            if (lcnt_q != 8'hFF) lcnt_d = lcnt_q + 8'd1;
          end else if (lcnt_q != 8'd0) begin
            lflag_d = 1'b0;
            lcnt_d  = lcnt_q - 8'd1;
          end
          if (lcnt_d > cfg_i.low_lim) begin
            lflag_d = 1'b1;
            rep     = 1'b1;
          end
          if (mx_q >= cfg_i.high_thr) begin
            if (hcnt_q != 8'hFF) hcnt_d = hcnt_q + 8'd1;
          end else if (hcnt_q != 8'd0) begin
            hflag_d = 1'b0;
            hcnt_d  = hcnt_q - 8'd1;
          end
          if (hcnt_d > cfg_i.high_lim) begin
            hflag_d = 1'b1;
            rep     = 1'b1;
          end
          pmin_d   = mn_q;
          bal_en_d = 1'b1;

          out_d            = '0;
          out_d.kind       = bpmb_pkg::KIND_PACK;
          out_d.pmin       = mn_q;
          out_d.pmax       = mx_q;
          // reciprocal quotient is at most one low
          out_d.pavg       = (rem >= TOTAL_W'(NUM_CELLS)) ? quo_q + 16'd1 : quo_q;
          out_d.total      = 23'(sum_q);
          out_d.low_fault  = lflag_d;
          out_d.high_fault = hflag_d;
          out_d.report     = rep;
          out_valid_d      = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    rd_vld_q <= vld_q[raddr];
    mn_q     <= mn_d;
    mx_q     <= mx_d;
    sum_q    <= sum_d;
    prod_q   <= PROD_W'(sum_q) * PROD_W'(RECIP);
    quo_q    <= prod_q[47:32];
    qn_q     <= TOTAL_W'(quo_q) * TOTAL_W'(NUM_CELLS);
    out_q    <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      vld_q       <= '0;
      bmax_q      <= 16'd0;
      bidx_q      <= 4'd0;
      pmin_q      <= 16'd0;
      bal_en_q    <= 1'b0;
      lcnt_q      <= 8'd0;
      hcnt_q      <= 8'd0;
      lflag_q     <= 1'b0;
      hflag_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      if (ram_we) begin
        vld_q[waddr] <= 1'b1;
      end
      bmax_q      <= bmax_d;
      bidx_q      <= bidx_d;
      pmin_q      <= pmin_d;
      bal_en_q    <= bal_en_d;
      lcnt_q      <= lcnt_d;
      hcnt_q      <= hcnt_d;
      lflag_q     <= lflag_d;
      hflag_q     <= hflag_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_pop_o |-> (state_q == ST_IDLE) && item_valid_i)
    else $error("item taken while back end busy");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (cnt_q <= CNT_W'(NUM_CELLS)))
    else $error("walk counter ran past the store");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |-> (qn_q <= sum_q) && (rem < TOTAL_W'(2 * NUM_CELLS)))
    else $error("average quotient off by more than one");

  a_summary_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) && out_free |=> out_valid_q && (out_q.kind == bpmb_pkg::KIND_PACK))
    else $error("pack summary not loaded");

endmodule

// ===== dv/battery_pack_monitor_balancer_tb.sv =====
`timescale 1ns / 100ps

module battery_pack_monitor_balancer_tb;

  localparam int NCELL       = 96;
  localparam int BRD         = 12;
  // evaluate walks the store plus divide; allow two of them in flight
  localparam int SETTLE      = 2 * (NCELL + 6) + 20;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    logic        op;
    logic [15:0] code;
    logic [6:0]  pos;
    logic [3:0]  idx;
    logic        last;
    logic        pec;
  } cell_beat_t;

  typedef struct {
    cell_beat_t     b;
    bit             typed;
    bpmb_pkg::res_t want;
  } stim_row_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_addr_i    = '0;
  logic [15:0] cfg_data_i    = '0;

  // predicted block state
  logic [15:0]    cells_m [NCELL];
  logic [15:0]    brd_max;
  logic [3:0]     brd_idx;
  logic [15:0]    min_held;
  logic [7:0]     lo_cnt;
  logic [7:0]     hi_cnt;
  logic           lo_flag;
  logic           hi_flag;
  logic           bal_en;
  bpmb_pkg::cfg_t cfg_m;

  stim_row_t      dir_tab [$];
  stim_row_t      stim_q [$];
  bpmb_pkg::res_t exp_q [$];
  stim_row_t      cur_row;

  int          err_cnt    = 0;
  int          cyc_cnt    = 0;
  int          gap_left   = 0;
  int          burst_left = 0;
  bit          gaps_on    = 1'b1;
  int          rdy_hold   = 0;
  int          rdy_mode   = 0;
  int          rdy_count  = 0;

  battery_pack_monitor_balancer #(
    .NUM_CELLS       (NCELL),
    .CELLS_PER_BOARD (BRD)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic predict_beat(input cell_beat_t b, output bit has_res,
                              output bpmb_pkg::res_t r);
    logic [22:0] sum;
    logic [15:0] mn;
    logic [15:0] mx;
    r       = '0;
    has_res = 1'b0;
    if (b.op == bpmb_pkg::OP_SAMPLE) begin
      if (b.pos < 7'(NCELL)) cells_m[b.pos] = b.code;
      if (b.idx < 4'(BRD) && b.code > brd_max) begin
        brd_max = b.code;
        brd_idx = b.idx;
      end
      if (b.last) begin
        has_res = 1'b1;
        r.kind  = bpmb_pkg::KIND_BOARD;
        if (!b.pec) begin
          r.action = bpmb_pkg::ACT_PEC_ERR;
        end else if (bal_en && {1'b0, brd_max} > {1'b0, min_held} + {1'b0, cfg_m.margin} &&
                     brd_max > cfg_m.floor) begin
          r.action = bpmb_pkg::ACT_DISCHARGE;
          r.mask   = 12'd1 << brd_idx;
        end else begin
          r.action = bpmb_pkg::ACT_HOLD;
        end
        brd_max      = '0;
        brd_idx      = '0;
        r.low_fault  = lo_flag;
        r.high_fault = hi_flag;
      end
    end else begin
      sum = '0;
      mn  = '1;
      mx  = '0;
      for (int k = 0; k < NCELL; k++) begin
        sum += 23'(cells_m[k]);
        if (cells_m[k] < mn) mn = cells_m[k];
        if (cells_m[k] > mx) mx = cells_m[k];
      end
      min_held = mn;
      if (mn < cfg_m.low_thr) begin
        if (lo_cnt != 8'hFF) lo_cnt++;
      end else if (lo_cnt != 8'd0) begin
        lo_flag = 1'b0;
        lo_cnt--;
      end
      if (lo_cnt > cfg_m.low_lim) begin
        lo_flag  = 1'b1;
        r.report = 1'b1;
      end
      if (mx >= cfg_m.high_thr) begin
        if (hi_cnt != 8'hFF) hi_cnt++;
      end else if (hi_cnt != 8'd0) begin
        hi_flag = 1'b0;
        hi_cnt--;
      end
      if (hi_cnt > cfg_m.high_lim) begin
        hi_flag  = 1'b1;
        r.report = 1'b1;
      end
      bal_en       = 1'b1;
      has_res      = 1'b1;
      r.kind       = bpmb_pkg::KIND_PACK;
      r.pmin       = mn;
      r.pmax       = mx;
      r.pavg       = 16'(sum / 23'(NCELL));
      r.total      = sum;
      r.low_fault  = lo_flag;
      r.high_fault = hi_flag;
    end
  endtask

  task automatic report_mismatch(input string fld, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s, got 0x%0h, want 0x%0h", $time, fld, got, want);
    err_cnt++;
  endtask

  function automatic void add_row(input logic op, input logic [15:0] code,
                                  input logic [6:0] pos, input logic [3:0] idx,
                                  input logic last, input logic pec, input bit typed,
                                  input logic [1:0] act, input logic [11:0] mask);
    stim_row_t row;
    row.b.op        = op;
    row.b.code      = code;
    row.b.pos       = pos;
    row.b.idx       = idx;
    row.b.last      = last;
    row.b.pec       = pec;
    row.typed       = typed;
    row.want        = '0;
    row.want.kind   = (op == bpmb_pkg::OP_EVAL) ? bpmb_pkg::KIND_PACK : bpmb_pkg::KIND_BOARD;
    row.want.action = act;
    row.want.mask   = mask;
    dir_tab.push_back(row);
  endfunction

  task automatic queue_evals(input int n);
    stim_row_t row;
    row.typed = 1'b0;
    row.want  = '0;
    for (int i = 0; i < n; i++) begin
      row.b.op   = bpmb_pkg::OP_EVAL;
      row.b.code = 16'($urandom);
      row.b.pos  = 7'($urandom);
      row.b.idx  = 4'($urandom);
      row.b.last = 1'($urandom);
      row.b.pec  = 1'($urandom);
      stim_q.push_back(row);
    end
  endtask

  // one full pass over the pack, board by board, then an evaluate
  task automatic queue_pack_sweep(input int lo, input int hi, input int noise_pct);
    stim_row_t row;
    row.typed = 1'b0;
    row.want  = '0;
    for (int p = 0; p < NCELL; p++) begin
      row.b.op   = bpmb_pkg::OP_SAMPLE;
      row.b.code = 16'($urandom_range(lo, hi));
      if ($urandom_range(0, 15) == 0) row.b.code = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      row.b.pos  = 7'(p);
      row.b.idx  = 4'(p % BRD);
      row.b.last = (p % BRD == BRD - 1);
      row.b.pec  = row.b.last ? ($urandom_range(0, 7) != 0) : 1'($urandom);
      if ($urandom_range(0, 99) < noise_pct) begin
        row.b.op   = ($urandom_range(0, 7) == 0) ? bpmb_pkg::OP_EVAL : bpmb_pkg::OP_SAMPLE;
        row.b.code = 16'($urandom);
        row.b.pos  = 7'($urandom);
        row.b.idx  = 4'($urandom);
        row.b.last = 1'($urandom);
        row.b.pec  = 1'($urandom);
      end
      stim_q.push_back(row);
    end
    queue_evals(1);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [15:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (addr)
      bpmb_pkg::REG_LOW_THR:  cfg_m.low_thr  = val;
      bpmb_pkg::REG_HIGH_THR: cfg_m.high_thr = val;
      bpmb_pkg::REG_MARGIN:   cfg_m.margin   = val;
      bpmb_pkg::REG_FLOOR:    cfg_m.floor    = val;
      bpmb_pkg::REG_LOW_LIM:  cfg_m.low_lim  = val[7:0];
      bpmb_pkg::REG_HIGH_LIM: cfg_m.high_lim = val[7:0];
      default: ;
    endcase
  endtask

  // all beats sent, all results back, then let trailing samples retire
  task automatic wait_idle();
    while (stim_q.size() != 0 || s_axis_tvalid || exp_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // sender: bursts of beats with random gaps
  always @(posedge clk_i) begin
    bit             has;
    bpmb_pkg::res_t r;
    bit             drive;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_beat(cur_row.b, has, r);
        if (has) exp_q.push_back(cur_row.typed ? cur_row.want : r);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        drive = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (stim_q.size() > 0) begin
          cur_row = stim_q.pop_front();
          drive   = 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = (gaps_on && $urandom_range(0, 3) != 0) ? $urandom_range(1, 12) : 0;
          end
        end
        s_axis_tvalid <= drive;
        s_axis_tdata  <= {4'b0, cur_row.b.pec, cur_row.b.idx, cur_row.b.pos, cur_row.b.code};
        s_axis_tuser  <= cur_row.b.op;
        s_axis_tlast  <= cur_row.b.last;
      end
    end
  end

  // receiver: stall pattern is redrawn at random from three modes: none, short holds, long holds
  always @(posedge clk_i) begin
    if (rst_ni) begin
      rdy_count++;
      if (rdy_count % 256 == 0) rdy_mode = $urandom_range(0, 2);
      if (rdy_hold > 0) begin
        rdy_hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        case (rdy_mode)
          1: if ($urandom_range(0, 1) == 0) rdy_hold = $urandom_range(1, 3);
          2: if ($urandom_range(0, 15) == 0) rdy_hold = $urandom_range(5, 40);
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    bpmb_pkg::res_t got;
    bpmb_pkg::res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.kind       = m_axis_tuser;
      got.action     = m_axis_tdata[1:0];
      got.mask       = m_axis_tdata[13:2];
      got.pmin       = m_axis_tdata[29:14];
      got.pmax       = m_axis_tdata[45:30];
      got.pavg       = m_axis_tdata[61:46];
      got.total      = m_axis_tdata[84:62];
      got.low_fault  = m_axis_tdata[85];
      got.high_fault = m_axis_tdata[86];
      got.report     = m_axis_tdata[87];
      if (exp_q.size() == 0) begin
        report_mismatch("unexpected result beat", 32'(got.kind), 32'hFFFF_FFFF);
      end else begin
        want = exp_q.pop_front();
        if (got.kind !== want.kind)
          report_mismatch("result_kind", 32'(got.kind), 32'(want.kind));
        if (got.action !== want.action)
          report_mismatch("balance_action", 32'(got.action), 32'(want.action));
        if (got.mask !== want.mask)
          report_mismatch("discharge_mask", 32'(got.mask), 32'(want.mask));
        if (got.pmin !== want.pmin)
          report_mismatch("pack_minimum", 32'(got.pmin), 32'(want.pmin));
        if (got.pmax !== want.pmax)
          report_mismatch("pack_maximum", 32'(got.pmax), 32'(want.pmax));
        if (got.pavg !== want.pavg)
          report_mismatch("pack_average", 32'(got.pavg), 32'(want.pavg));
        if (got.total !== want.total)
          report_mismatch("pack_total", 32'(got.total), 32'(want.total));
        if (got.low_fault !== want.low_fault)
          report_mismatch("low_fault", 32'(got.low_fault), 32'(want.low_fault));
        if (got.high_fault !== want.high_fault)
          report_mismatch("high_fault", 32'(got.high_fault), 32'(want.high_fault));
        if (got.report !== want.report)
          report_mismatch("fault_report", 32'(got.report), 32'(want.report));
      end
    end
  end

  always @(posedge clk_i) begin
    cyc_cnt++;
    if (cyc_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, exp_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    foreach (cells_m[k]) cells_m[k] = '0;
    brd_max  = '0;
    brd_idx  = '0;
    min_held = '0;
    lo_cnt   = '0;
    hi_cnt   = '0;
    lo_flag  = 1'b0;
    hi_flag  = 1'b0;
    bal_en   = 1'b0;
    cfg_m    = '{low_thr: bpmb_pkg::RST_LOW_THR, high_thr: bpmb_pkg::RST_HIGH_THR,
                 margin: bpmb_pkg::RST_MARGIN, floor: bpmb_pkg::RST_FLOOR,
                 low_lim: bpmb_pkg::RST_LOW_LIM, high_lim: bpmb_pkg::RST_HIGH_LIM};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table; summary rows carry action 0
    //      op                   code      pos   idx   lst   pec   typed
    //      action                   mask
    add_row(bpmb_pkg::OP_EVAL,   16'h0000, 7'd0, 4'd0, 1'b0, 1'b0, 1'b1,
            bpmb_pkg::ACT_DISCHARGE, 12'h000);
    add_row(bpmb_pkg::OP_SAMPLE, 16'hFFFF, 7'd0, 4'd0, 1'b0, 1'b1, 1'b0,
            bpmb_pkg::ACT_DISCHARGE, 12'h000);
    add_row(bpmb_pkg::OP_SAMPLE, 16'h0000, 7'd95, 4'd11, 1'b1, 1'b0, 1'b1,
            bpmb_pkg::ACT_PEC_ERR, 12'h000);
    // out-of-range position and board index, then discharge on index 11
    add_row(bpmb_pkg::OP_SAMPLE, 16'd40000, 7'd127, 4'd15, 1'b0, 1'b1, 1'b0,
            bpmb_pkg::ACT_DISCHARGE, 12'h000);
    add_row(bpmb_pkg::OP_SAMPLE, 16'd50000, 7'd1, 4'd11, 1'b1, 1'b1, 1'b1,
            bpmb_pkg::ACT_DISCHARGE, 12'h800);
    // tie keeps the first cell
    add_row(bpmb_pkg::OP_SAMPLE, 16'd35000, 7'd2, 4'd3, 1'b0, 1'b1, 1'b0,
            bpmb_pkg::ACT_DISCHARGE, 12'h000);
    add_row(bpmb_pkg::OP_SAMPLE, 16'd35000, 7'd3, 4'd5, 1'b1, 1'b1, 1'b1,
            bpmb_pkg::ACT_DISCHARGE, 12'h008);
    // board max equal to floor, then an all-zero board
    add_row(bpmb_pkg::OP_SAMPLE, 16'd32000, 7'd4, 4'd0, 1'b1, 1'b1, 1'b1,
            bpmb_pkg::ACT_HOLD, 12'h000);
    add_row(bpmb_pkg::OP_SAMPLE, 16'd0, 7'd5, 4'd0, 1'b1, 1'b1, 1'b1,
            bpmb_pkg::ACT_HOLD, 12'h000);
    // low counter climbs past its limit
    add_row(bpmb_pkg::OP_EVAL,   16'h0000, 7'd0, 4'd0, 1'b0, 1'b0, 1'b0,
            bpmb_pkg::ACT_DISCHARGE, 12'h000);
    add_row(bpmb_pkg::OP_EVAL,   16'h0000, 7'd0, 4'd0, 1'b0, 1'b0, 1'b0,
            bpmb_pkg::ACT_DISCHARGE, 12'h000);
    add_row(bpmb_pkg::OP_EVAL,   16'h0000, 7'd0, 4'd0, 1'b0, 1'b0, 1'b0,
            bpmb_pkg::ACT_DISCHARGE, 12'h000);
    add_row(bpmb_pkg::OP_EVAL,   16'h0000, 7'd0, 4'd0, 1'b0, 1'b0, 1'b0,
            bpmb_pkg::ACT_DISCHARGE, 12'h000);
    add_row(bpmb_pkg::OP_EVAL,   16'h0000, 7'd0, 4'd0, 1'b0, 1'b0, 1'b0,
            bpmb_pkg::ACT_DISCHARGE, 12'h000);
    add_row(bpmb_pkg::OP_SAMPLE, 16'hFFFF, 7'd94, 4'd11, 1'b1, 1'b1, 1'b0,
            bpmb_pkg::ACT_DISCHARGE, 12'h000);
    add_row(bpmb_pkg::OP_EVAL,   16'hFFFF, 7'h7F, 4'hF, 1'b1, 1'b1, 1'b0,
            bpmb_pkg::ACT_DISCHARGE, 12'h000);
    add_row(bpmb_pkg::OP_SAMPLE, 16'hFFFF, 7'd6, 4'd12, 1'b1, 1'b1, 1'b0,
            bpmb_pkg::ACT_DISCHARGE, 12'h000);
    add_row(bpmb_pkg::OP_SAMPLE, 16'h1234, 7'd7, 4'd2, 1'b0, 1'b0, 1'b0,
            bpmb_pkg::ACT_DISCHARGE, 12'h000);
    add_row(bpmb_pkg::OP_SAMPLE, 16'h8001, 7'd8, 4'd9, 1'b1, 1'b1, 1'b0,
            bpmb_pkg::ACT_DISCHARGE, 12'h000);
    foreach (dir_tab[i]) stim_q.push_back(dir_tab[i]);
    wait_idle();

    // reset settings, random packs; drain once in between
    queue_pack_sweep(29000, 43000, 5);
    wait_idle();
    queue_pack_sweep(0, 65535, 10);
    queue_evals(2);
    wait_idle();

    // every evaluation is an event: both counters run into saturation
    write_reg(bpmb_pkg::REG_LOW_THR, 16'hFFFF);
    write_reg(bpmb_pkg::REG_HIGH_THR, 16'h0000);
    write_reg(bpmb_pkg::REG_MARGIN, 16'h0000);
    write_reg(bpmb_pkg::REG_FLOOR, 16'h0000);
    write_reg(bpmb_pkg::REG_LOW_LIM, 16'h0000);
    write_reg(bpmb_pkg::REG_HIGH_LIM, 16'h00FE);
    gaps_on = 1'b0;
    queue_pack_sweep(0, 65535, 0);
    queue_evals(258);
    wait_idle();

    // no low events: the low counter walks down, balancing never passes
    write_reg(bpmb_pkg::REG_LOW_THR, 16'h0000);
    write_reg(bpmb_pkg::REG_HIGH_THR, 16'hFFFF);
    write_reg(bpmb_pkg::REG_MARGIN, 16'hFFFF);
    write_reg(bpmb_pkg::REG_FLOOR, 16'hFFFF);
    write_reg(bpmb_pkg::REG_LOW_LIM, 16'hFFFF);
    write_reg(bpmb_pkg::REG_HIGH_LIM, 16'hFF00);
    gaps_on = 1'b1;
    queue_pack_sweep(0, 65534, 5);
    queue_evals(20);
    wait_idle();

    for (int ph = 0; ph < 3; ph++) begin
      write_reg(bpmb_pkg::REG_LOW_THR, 16'($urandom_range(28000, 34000)));
      write_reg(bpmb_pkg::REG_HIGH_THR, 16'($urandom_range(38000, 45000)));
      write_reg(bpmb_pkg::REG_MARGIN, 16'($urandom_range(0, 2000)));
      write_reg(bpmb_pkg::REG_FLOOR, 16'($urandom_range(30000, 36000)));
      write_reg(bpmb_pkg::REG_LOW_LIM, 16'($urandom_range(0, 12)));
      write_reg(bpmb_pkg::REG_HIGH_LIM, 16'($urandom_range(0, 12)));
      gaps_on = (ph != 1);
      queue_pack_sweep(29000, 43000, 4);
      queue_evals($urandom_range(0, 3));
      queue_pack_sweep($urandom_range(0, 35000), $urandom_range(35000, 65535), 4);
      wait_idle();
    end

    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
